@@ src/g2wdc_pkg.sv @@
// ----------------------------------------------------------------------------
// g2wdc_pkg
// Shared types and constants for the wavelet detail coefficient block.
// ----------------------------------------------------------------------------
`default_nettype none

package g2wdc_pkg;

   localparam int PHI_DEPTH = 64;
   localparam int PSI_DEPTH = 64;
   localparam int PHI_AW    = $clog2(PHI_DEPTH);
   localparam int PSI_AW    = $clog2(PSI_DEPTH);
   localparam int PHI_CW    = $clog2(PHI_DEPTH + 1);
   localparam int PSI_CW    = $clog2(PSI_DEPTH + 1);
   localparam int IDX_W     = (PHI_AW > PSI_AW) ? PHI_AW : PSI_AW;

   // compute queue, power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_PHI  = 2'd0;
   localparam logic [1:0] KIND_PSI  = 2'd1;
   localparam logic [1:0] KIND_CALC = 2'd2;

   localparam logic [2:0] CSR_PHI_COUNT  = 3'd0;
   localparam logic [2:0] CSR_PSI_COUNT  = 3'd1;
   localparam logic [2:0] CSR_SCALE_EXP  = 3'd2;
   localparam logic [2:0] CSR_STEP_X     = 3'd3;
   localparam logic [2:0] CSR_STEP_Y     = 3'd4;
   localparam logic [2:0] CSR_SINGULAR_X = 3'd5;
   localparam logic [2:0] CSR_SINGULAR_Y = 3'd6;

   localparam logic [31:0] LN2_Q32    = 32'd2977044472;
   localparam logic [31:0] INV4PI_Q32 = 32'd341782638;

   typedef struct packed {
      logic [6:0]         phi_count;
      logic [6:0]         psi_count;
      logic signed [4:0]  scale_exponent;
      logic [31:0]        step_x;
      logic [31:0]        step_y;
      logic signed [31:0] singular_x;
      logic signed [31:0] singular_y;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      phi_count:      7'd64,
      psi_count:      7'd64,
      scale_exponent: 5'sd0,
      step_x:         32'd262144,
      step_y:         32'd262144,
      singular_x:     32'sd0,
      singular_y:     32'sd0
   };

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
   } cmd_type;

endpackage

`default_nettype wire

@@ src/g2wdc_ram.sv @@
// ----------------------------------------------------------------------------
// g2wdc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module g2wdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/g2wdc_front.sv @@
// ----------------------------------------------------------------------------
// g2wdc_front
// Accepts request transfers, writes table loads, queues compute commands.
// ----------------------------------------------------------------------------
`default_nettype none

module g2wdc_front
   import g2wdc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_kind,
   input  wire logic [5:0]        req_entry_index,
   input  wire logic [31:0]       req_table_value,
   input  wire logic [15:0]       req_pos_x,
   input  wire logic [15:0]       req_pos_y,
   input  wire logic              back_busy,
   output logic                   phi_we,
   output logic [PHI_AW-1:0]      phi_wr_addr,
   output logic                   psi_we,
   output logic [PSI_AW-1:0]      psi_wr_addr,
   output logic [31:0]            wr_data,
   output logic                   q_valid,
   output cmd_type                q_cmd,
   input  wire logic              q_pop
);

   cmd_type               q_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;
   logic                  fire, push, q_empty, q_full;

   assign q_empty = (cnt_ff == '0);
   assign q_full  = (cnt_ff == QUEUE_CW'(QUEUE_DEPTH));

   // loads wait until no queued or running compute still reads the tables
   always_comb begin
      case (req_kind)
         KIND_PHI, KIND_PSI: req_ready = q_empty && !back_busy;
         KIND_CALC:          req_ready = !q_full;
         default:            req_ready = 1'b1;
      endcase
   end

   assign fire = req_valid && req_ready;
   assign push = fire && (req_kind == KIND_CALC);

   assign phi_we      = fire && (req_kind == KIND_PHI) && (32'(req_entry_index) < PHI_DEPTH);
   assign psi_we      = fire && (req_kind == KIND_PSI) && (32'(req_entry_index) < PSI_DEPTH);
   assign phi_wr_addr = PHI_AW'(req_entry_index);
   assign psi_wr_addr = PSI_AW'(req_entry_index);
   assign wr_data     = req_table_value;

   assign q_valid = !q_empty;
   assign q_cmd   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && q_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= '{pos_x: req_pos_x, pos_y: req_pos_y};
      end
   end

endmodule

`default_nettype wire

@@ src/g2wdc_back.sv @@
// ----------------------------------------------------------------------------
// g2wdc_back
// Compute engine: double sum of table products times log radius, then scale.
// ----------------------------------------------------------------------------
`default_nettype none

module g2wdc_back
   import g2wdc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              q_valid,
   input  wire cmd_type           q_cmd,
   output logic                   q_pop,
   output logic                   busy,
   output logic [PHI_AW-1:0]      phi_rd_addr,
   input  wire logic [31:0]       phi_rd_data,
   output logic [PSI_AW-1:0]      psi_rd_addr,
   input  wire logic [31:0]       psi_rd_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [63:0]            rsp_coefficient,
   output logic                   rsp_hit_singularity
);

   typedef enum logic [17:0] {
      ST_IDLE = 18'b000000000000000001,
      ST_XV   = 18'b000000000000000010,
      ST_XS   = 18'b000000000000000100,
      ST_YV   = 18'b000000000000001000,
      ST_YS   = 18'b000000000000010000,
      ST_SQX  = 18'b000000000000100000,
      ST_SQY  = 18'b000000000001000000,
      ST_NORM = 18'b000000000010000000,
      ST_LOG  = 18'b000000000100000000,
      ST_LN   = 18'b000000001000000000,
      ST_TERM = 18'b000000010000000000,
      ST_KXY  = 18'b000000100000000000,
      ST_KMUL = 18'b000001000000000000,
      ST_K2   = 18'b000010000000000000,
      ST_MMUL = 18'b000100000000000000,
      ST_RND  = 18'b001000000000000000,
      ST_SHF  = 18'b010000000000000000,
      ST_OUT  = 18'b100000000000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [PHI_AW-1:0]  px_ff, px_in;
   logic [PSI_AW-1:0]  py_ff, py_in;
   cmd_type            cmd_ff, cmd_in;
   logic signed [63:0] v_ff, v_in;
   logic signed [31:0] xx_ff, xx_in;
   logic signed [31:0] yy_ff, yy_in;
   logic [63:0]        sqx_ff, sqx_in;
   logic [63:0]        r_ff, r_in;
   logic signed [33:0] pp_ff, pp_in;
   logic [5:0]         sh_ff, sh_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [31:0]        m_ff, m_in;
   logic [23:0]        frac_ff, frac_in;
   logic signed [31:0] lg_ff, lg_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               hit_ff, hit_in;
   logic [63:0]        mw_a_ff, mw_a_in;
   logic [63:0]        mw_b_ff, mw_b_in;
   logic [127:0]       prod_ff, prod_in;
   logic               neg_ff, neg_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [63:0]        coef_ff, coef_in;
   logic               rhit_ff, rhit_in;

   // clamped counts
   logic [PHI_CW-1:0]  pc;
   logic [PSI_CW-1:0]  qc;
   logic               px_last, py_last;

   // coordinate unit
   logic                   is_y;
   logic [IDX_W-1:0]       cu_idx;
   logic [31:0]            cu_step;
   logic signed [15:0]     cu_n;
   logic [IDX_W+31:0]      cu_prod;
   logic signed [63:0]     cu_v;
   logic signed [4:0]      jexp;
   logic [4:0]             rs;
   logic signed [63:0]     vs, cu_d, cu_zx;
   logic signed [31:0]     cu_z, cu_sat;

   // log path
   logic [6:0]         w;
   logic               top_zero;
   logic [63:0]        r_nx;
   logic [5:0]         sh_nx;
   logic [63:0]        msq;
   logic [32:0]        mt;
   logic [5:0]         ip;
   logic signed [29:0] l2;
   logic signed [62:0] lnp;
   logic signed [63:0] phprod;
   logic signed [65:0] tp;
   logic signed [63:0] tc;

   // wide multiply and final scaling
   logic [63:0]        mw_pa;
   logic [127:0]       mw_sh;
   logic [6:0]         s_amt;
   logic [63:0]        mag, res;
   logic               ovf;

   always_comb begin
      if (32'(cfg.phi_count) > PHI_DEPTH) begin
         pc = PHI_CW'(PHI_DEPTH);
      end else begin
         pc = PHI_CW'(cfg.phi_count);
      end
      if (32'(cfg.psi_count) > PSI_DEPTH) begin
         qc = PSI_CW'(PSI_DEPTH);
      end else begin
         qc = PSI_CW'(cfg.psi_count);
      end
   end

   assign px_last = (PHI_CW'(px_ff) + PHI_CW'(1)) == pc;
   assign py_last = (PSI_CW'(py_ff) + PSI_CW'(1)) == qc;

   assign phi_rd_addr = px_ff;
   assign psi_rd_addr = py_ff;

   // coordinate: v = idx*step + n*2^24, then scale by 2^(J-8), subtract, saturate
   assign is_y    = (state_ff == ST_YV) || (state_ff == ST_YS);
   assign cu_idx  = is_y ? IDX_W'(py_ff) : IDX_W'(px_ff);
   assign cu_step = is_y ? cfg.step_y : cfg.step_x;
   assign cu_n    = is_y ? cmd_ff.pos_y : cmd_ff.pos_x;
   assign cu_prod = cu_idx * cu_step;
   assign cu_v    = $signed({{(32-IDX_W){1'b0}}, cu_prod})
                    + ($signed({{48{cu_n[15]}}, cu_n}) <<< 24);
   assign jexp    = cfg.scale_exponent;
   assign rs      = 5'd8 - jexp;
   assign cu_z    = is_y ? cfg.singular_y : cfg.singular_x;
   assign cu_zx   = {{32{cu_z[31]}}, cu_z};

   always_comb begin
      if (!jexp[4] && jexp[3]) begin
         vs = v_ff <<< jexp[2:0];
      end else begin
         vs = (v_ff + $signed(64'(1) << (rs - 5'd1))) >>> rs;
      end
      cu_d = vs - cu_zx;
      if (cu_d > 64'sd2147483647) begin
         cu_sat = 32'sh7FFFFFFF;
      end else if (cu_d < -64'sd2147483648) begin
         cu_sat = 32'sh80000000;
      end else begin
         cu_sat = cu_d[31:0];
      end
   end

   // normalize: binary search of the leading one, 32/16/8/4/2/1
   assign w        = 7'd32 >> cnt_ff[2:0];
   assign top_zero = (r_ff >> (7'd64 - w)) == 64'd0;
   assign r_nx     = top_zero ? (r_ff << w) : r_ff;
   assign sh_nx    = top_zero ? (sh_ff + 6'(w)) : sh_ff;

   assign msq = 64'(m_ff) * 64'(m_ff);
   assign mt  = msq[63:31];

   assign ip  = 6'd31 - sh_ff;
   assign l2  = $signed({ip, frac_ff});
   assign lnp = l2 * $signed({1'b0, LN2_Q32});

   assign phprod = $signed(phi_rd_data) * $signed(psi_rd_data);
   assign tp     = pp_ff * lg_ff;
   assign tc     = 64'((tp + 66'sd2097152) >>> 22);

   assign mw_pa = 64'(mw_a_ff[32*cnt_ff[0] +: 32]) * 64'(mw_b_ff[32*cnt_ff[1] +: 32]);
   assign mw_sh = {64'd0, mw_pa} << {({1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]}), 5'd0};

   assign s_amt = 7'd48 - {{2{jexp[4]}}, jexp};
   assign mag   = acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
   assign res   = prod_ff[63:0];
   assign ovf   = (prod_ff[127:64] != 64'd0) || prod_ff[63];

   always_comb begin
      state_in     = state_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cmd_in       = cmd_ff;
      v_in         = v_ff;
      xx_in        = xx_ff;
      yy_in        = yy_ff;
      sqx_in       = sqx_ff;
      r_in         = r_ff;
      pp_in        = pp_ff;
      sh_in        = sh_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      frac_in      = frac_ff;
      lg_in        = lg_ff;
      acc_in       = acc_ff;
      hit_in       = hit_ff;
      mw_a_in      = mw_a_ff;
      mw_b_in      = mw_b_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      coef_in      = coef_ff;
      rhit_in      = rhit_ff;
      q_pop        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid && !rsp_valid_ff) begin
               q_pop  = 1'b1;
               cmd_in = q_cmd;
               acc_in = '0;
               hit_in = 1'b0;
               px_in  = '0;
               py_in  = '0;
               if ((pc == '0) || (qc == '0)) begin
                  state_in = ST_KXY;
               end else begin
                  state_in = ST_XV;
               end
            end
         end
         ST_XV: begin
            v_in     = cu_v;
            state_in = ST_XS;
         end
         ST_XS: begin
            xx_in    = cu_sat;
            py_in    = '0;
            state_in = ST_YV;
         end
         ST_YV: begin
            v_in     = cu_v;
            state_in = ST_YS;
         end
         ST_YS: begin
            yy_in    = cu_sat;
            state_in = ST_SQX;
         end
         ST_SQX: begin
            sqx_in   = 64'(xx_ff * xx_ff);
            state_in = ST_SQY;
         end
         ST_SQY: begin
            r_in     = sqx_ff + 64'(yy_ff * yy_ff);
            pp_in    = 34'((phprod + 64'sd536870912) >>> 30);
            sh_in    = '0;
            cnt_in   = '0;
            state_in = ST_NORM;
         end
         ST_NORM: begin
            if (r_ff == 64'd0) begin
               lg_in    = 32'sh80000000;
               hit_in   = 1'b1;
               state_in = ST_TERM;
            end else begin
               r_in   = r_nx;
               sh_in  = sh_nx;
               cnt_in = cnt_ff + 5'd1;
               if (cnt_ff == 5'd5) begin
                  m_in     = r_nx[63:32];
                  frac_in  = '0;
                  cnt_in   = '0;
                  state_in = ST_LOG;
               end
            end
         end
         ST_LOG: begin
            if (mt[32]) begin
               m_in    = mt[32:1];
               frac_in = {frac_ff[22:0], 1'b1};
            end else begin
               m_in    = mt[31:0];
               frac_in = {frac_ff[22:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd23) begin
               state_in = ST_LN;
            end
         end
         ST_LN: begin
            lg_in    = 32'((lnp + 63'sd2147483648) >>> 32);
            state_in = ST_TERM;
         end
         ST_TERM: begin
            acc_in = acc_ff + tc;
            if (!py_last) begin
               py_in    = py_ff + 1'b1;
               state_in = ST_YV;
            end else if (!px_last) begin
               px_in    = px_ff + 1'b1;
               state_in = ST_XV;
            end else begin
               state_in = ST_KXY;
            end
         end
         ST_KXY: begin
            mw_a_in  = 64'(cfg.step_x) * 64'(cfg.step_y);
            mw_b_in  = {32'd0, INV4PI_Q32};
            prod_in  = '0;
            cnt_in   = '0;
            state_in = ST_KMUL;
         end
         ST_KMUL, ST_MMUL: begin
            prod_in = prod_ff + mw_sh;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in   = '0;
               state_in = (state_ff == ST_KMUL) ? ST_K2 : ST_RND;
            end
         end
         ST_K2: begin
            mw_b_in  = 64'((prod_ff + 128'd2147483648) >> 32);
            mw_a_in  = mag;
            neg_in   = acc_ff[63];
            prod_in  = '0;
            cnt_in   = '0;
            state_in = ST_MMUL;
         end
         ST_RND: begin
            prod_in  = prod_ff + (128'd1 << (s_amt - 7'd1));
            state_in = ST_SHF;
         end
         ST_SHF: begin
            prod_in  = prod_ff >> s_amt;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (ovf) begin
               coef_in = neg_ff ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
            end else begin
               coef_in = neg_ff ? (64'd0 - res) : res;
            end
            rhit_in      = hit_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff   <= px_in;
      py_ff   <= py_in;
      cmd_ff  <= cmd_in;
      v_ff    <= v_in;
      xx_ff   <= xx_in;
      yy_ff   <= yy_in;
      sqx_ff  <= sqx_in;
      r_ff    <= r_in;
      pp_ff   <= pp_in;
      sh_ff   <= sh_in;
      cnt_ff  <= cnt_in;
      m_ff    <= m_in;
      frac_ff <= frac_in;
      lg_ff   <= lg_in;
      acc_ff  <= acc_in;
      hit_ff  <= hit_in;
      mw_a_ff <= mw_a_in;
      mw_b_ff <= mw_b_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
      coef_ff <= coef_in;
      rhit_ff <= rhit_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_coefficient     = coef_ff;
   assign rsp_hit_singularity = rhit_ff;

endmodule

`default_nettype wire

@@ src/green2d_wavelet_detail_coefficient.sv @@
// ----------------------------------------------------------------------------
// green2d_wavelet_detail_coefficient
// Load items are held back while a compute is queued or running.
// Compute items: a double sum over P by Q table entries, P and Q the clamped counts;
// each log term runs through one shared term engine (24 squaring steps).
// Synchronous reset clears control and loads register defaults; tables are
// not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module green2d_wavelet_detail_coefficient
   import g2wdc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [5:0]  req_entry_index,
   input  wire logic [31:0] req_table_value,
   input  wire logic [15:0] req_pos_x,
   input  wire logic [15:0] req_pos_y,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_coefficient,
   output logic             rsp_hit_singularity,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   cfg_type            cfg_ff, cfg_in;
   logic               back_busy, q_valid, q_pop;
   cmd_type            q_cmd;
   logic               phi_we, psi_we;
   logic [PHI_AW-1:0]  phi_wr_addr, phi_rd_addr;
   logic [PSI_AW-1:0]  psi_wr_addr, psi_rd_addr;
   logic [31:0]        wr_data, phi_rd_data, psi_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_PHI_COUNT:  cfg_in.phi_count      = csr_data[6:0];
            CSR_PSI_COUNT:  cfg_in.psi_count      = csr_data[6:0];
            CSR_SCALE_EXP:  cfg_in.scale_exponent = csr_data[4:0];
            CSR_STEP_X:     cfg_in.step_x         = csr_data;
            CSR_STEP_Y:     cfg_in.step_y         = csr_data;
            CSR_SINGULAR_X: cfg_in.singular_x     = csr_data;
            CSR_SINGULAR_Y: cfg_in.singular_y     = csr_data;
            default:        cfg_in                = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   g2wdc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_table_value (req_table_value),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .back_busy       (back_busy),
      .phi_we          (phi_we),
      .phi_wr_addr     (phi_wr_addr),
      .psi_we          (psi_we),
      .psi_wr_addr     (psi_wr_addr),
      .wr_data         (wr_data),
      .q_valid         (q_valid),
      .q_cmd           (q_cmd),
      .q_pop           (q_pop)
   );

   g2wdc_ram #(.WIDTH(32), .DEPTH(PHI_DEPTH)) u_phi_ram (
      .clock   (clock),
      .wr_en   (phi_we),
      .wr_addr (phi_wr_addr),
      .wr_data (wr_data),
      .rd_addr (phi_rd_addr),
      .rd_data (phi_rd_data)
   );

   g2wdc_ram #(.WIDTH(32), .DEPTH(PSI_DEPTH)) u_psi_ram (
      .clock   (clock),
      .wr_en   (psi_we),
      .wr_addr (psi_wr_addr),
      .wr_data (wr_data),
      .rd_addr (psi_rd_addr),
      .rd_data (psi_rd_data)
   );

   g2wdc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg_ff),
      .q_valid             (q_valid),
      .q_cmd               (q_cmd),
      .q_pop               (q_pop),
      .busy                (back_busy),
      .phi_rd_addr         (phi_rd_addr),
      .phi_rd_data         (phi_rd_data),
      .psi_rd_addr         (psi_rd_addr),
      .psi_rd_data         (psi_rd_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_coefficient     (rsp_coefficient),
      .rsp_hit_singularity (rsp_hit_singularity)
   );

endmodule

`default_nettype wire
